/* hw/rtl/rth_pkg.sv */
// ----------------------------------------------------------------------------
// rth_pkg
// Types and constants shared by the RGB to HSV conversion pipeline.
// ----------------------------------------------------------------------------
package rth_pkg;

  localparam logic [7:0] HsvFull     = 8'd255;
  localparam logic [7:0] HueSector   = 8'd43;
  localparam logic [7:0] HueGreenOfs = 8'd85;
  localparam logic [7:0] HueBlueOfs  = 8'd171;

  localparam int PrepStages = 2;
  localparam int DivSteps   = 8;
  localparam int Latency    = PrepStages + DivSteps + 1;

  localparam int LaneSat = 0;
  localparam int LaneHue = 1;

  typedef enum logic [1:0] {
    SectorRed,
    SectorGreen,
    SectorBlue
  } sector_t;

  typedef struct packed {
    logic [7:0] red_in;
    logic [7:0] green_in;
    logic [7:0] blue_in;
  } pixel_t;

  typedef struct packed {
    logic [7:0] chan0_out;
    logic [7:0] chan1_out;
    logic [7:0] chan2_out;
  } result_t;

  typedef struct packed {
    logic [7:0] rem;
    logic [7:0] quo;
    logic [7:0] den;
  } div_lane_t;

  typedef struct packed {
    logic       mode;
    pixel_t     pix;
    logic [7:0] value;
    logic [7:0] hue_ofs;
    logic       hue_neg;
    logic       zero_hue;
    logic       zero_sat;
  } side_t;

endpackage

/* hw/rtl/rgb_to_hsv_8bit.sv */
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit
// Pipelined 8-bit RGB to HSV converter with a pass-through mode.
//
//   Channel  Ports                        Transaction
//   input    start, busy, in_pixel        start high and busy low at a clock edge
//   result   out_valid, out_result        out_valid high for one cycle
//   config   cfg_valid, cfg_ready, cfg_data  cfg_valid and cfg_ready both high
//
// A pixel can be accepted in every cycle, and its result passes through
// two preparation stages, eight restoring division steps and an output stage.
// Busy and cfg_ready are constant, so nothing ever stalls.
// Reset is synchronous and clears the stage valid bits and the mode register.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  rth_pkg::pixel_t  in_pixel,
  output logic             out_valid,
  output rth_pkg::result_t out_result,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_data
);

  logic                     hsv_mode_r;
  logic                     in_accept;
  logic                     stg_valid [rth_pkg::DivSteps + 1];
  rth_pkg::div_lane_t [1:0] stg_lane  [rth_pkg::DivSteps + 1];
  rth_pkg::side_t           stg_side  [rth_pkg::DivSteps + 1];

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign in_accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hsv_mode_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      hsv_mode_r <= cfg_data;
    end
  end

  rth_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_accept),
    .in_mode   (hsv_mode_r),
    .in_pix    (in_pixel),
    .out_valid (stg_valid[0]),
    .out_lane  (stg_lane[0]),
    .out_side  (stg_side[0])
  );

  for (genvar s = 0; s < rth_pkg::DivSteps; s++) begin : g_div
    rth_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[s]),
      .in_lane   (stg_lane[s]),
      .in_side   (stg_side[s]),
      .out_valid (stg_valid[s + 1]),
      .out_lane  (stg_lane[s + 1]),
      .out_side  (stg_side[s + 1])
    );
  end

  rth_post u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (stg_valid[rth_pkg::DivSteps]),
    .in_lane    (stg_lane[rth_pkg::DivSteps]),
    .in_side    (stg_side[rth_pkg::DivSteps]),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  a_result_has_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_accept, rth_pkg::Latency))
    else $error("result without an accepted transaction");

  a_pass_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !$past(hsv_mode_r, rth_pkg::Latency)
      |-> out_result == $past(in_pixel, rth_pkg::Latency))
    else $error("pass-through result differs from the pixel");

  a_black_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(hsv_mode_r, rth_pkg::Latency) && out_result.chan2_out == 8'd0
      |-> out_result.chan0_out == 8'd0 && out_result.chan1_out == 8'd0)
    else $error("black pixel has nonzero hue or saturation");

endmodule

/* hw/rtl/rth_prep.sv */
// ----------------------------------------------------------------------------
// rth_prep
// Two register stages: channel extremes and hue sector, then the dividends.
// ----------------------------------------------------------------------------
module rth_prep (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_mode,
  input  rth_pkg::pixel_t                 in_pix,
  output logic                            out_valid,
  output rth_pkg::div_lane_t [1:0]        out_lane,
  output rth_pkg::side_t                  out_side
);

  logic             a_valid_r;
  logic             a_mode_r;
  rth_pkg::pixel_t  a_pix_r;
  logic [7:0]       a_hi_r;
  logic [7:0]       a_lo_r;
  rth_pkg::sector_t a_sector_r;
  logic             a_neg_r;
  logic [7:0]       a_mag_r;

  logic             a_mode_nxt;
  logic [7:0]       a_hi_nxt;
  logic [7:0]       a_lo_nxt;
  rth_pkg::sector_t a_sector_nxt;
  logic [8:0]       a_diff;
  logic [7:0]       a_mag_nxt;

  logic                     b_valid_r;
  rth_pkg::div_lane_t [1:0] b_lane_r;
  rth_pkg::side_t           b_side_r;

  logic [7:0]               b_delta;
  logic [15:0]              b_sat_num;
  logic [15:0]              b_hue_num;
  rth_pkg::div_lane_t [1:0] b_lane_nxt;
  rth_pkg::side_t           b_side_nxt;

  always_comb begin
    a_mode_nxt = in_mode;
    a_hi_nxt   = in_pix.red_in;
    a_lo_nxt   = in_pix.red_in;
    if (in_pix.green_in > a_hi_nxt) a_hi_nxt = in_pix.green_in;
    if (in_pix.blue_in > a_hi_nxt) a_hi_nxt = in_pix.blue_in;
    if (in_pix.green_in < a_lo_nxt) a_lo_nxt = in_pix.green_in;
    if (in_pix.blue_in < a_lo_nxt) a_lo_nxt = in_pix.blue_in;
    if (in_pix.red_in == a_hi_nxt) begin
      a_sector_nxt = rth_pkg::SectorRed;
      a_diff       = {1'b0, in_pix.green_in} - {1'b0, in_pix.blue_in};
    end else if (in_pix.green_in == a_hi_nxt) begin
      a_sector_nxt = rth_pkg::SectorGreen;
      a_diff       = {1'b0, in_pix.blue_in} - {1'b0, in_pix.red_in};
    end else begin
      a_sector_nxt = rth_pkg::SectorBlue;
      a_diff       = {1'b0, in_pix.red_in} - {1'b0, in_pix.green_in};
    end
    a_mag_nxt = a_diff[8] ? 8'(9'd0 - a_diff) : a_diff[7:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= in_valid;
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    a_mode_r   <= a_mode_nxt;
    a_pix_r    <= in_pix;
    a_hi_r     <= a_hi_nxt;
    a_lo_r     <= a_lo_nxt;
    a_sector_r <= a_sector_nxt;
    a_neg_r    <= a_diff[8];
    a_mag_r    <= a_mag_nxt;
  end

  always_comb begin
    b_delta   = a_hi_r - a_lo_r;
    b_sat_num = {b_delta, 8'd0} - {8'd0, b_delta};
    b_hue_num = 16'(rth_pkg::HueSector) * {8'd0, a_mag_r};

    b_lane_nxt[rth_pkg::LaneSat].rem = b_sat_num[15:8];
    b_lane_nxt[rth_pkg::LaneSat].quo = b_sat_num[7:0];
    b_lane_nxt[rth_pkg::LaneSat].den = a_hi_r;
    b_lane_nxt[rth_pkg::LaneHue].rem = b_hue_num[15:8];
    b_lane_nxt[rth_pkg::LaneHue].quo = b_hue_num[7:0];
    b_lane_nxt[rth_pkg::LaneHue].den = b_delta;

    b_side_nxt.mode     = a_mode_r;
    b_side_nxt.pix      = a_pix_r;
    b_side_nxt.value    = a_hi_r;
    b_side_nxt.hue_neg  = a_neg_r;
    b_side_nxt.zero_hue = (b_delta == 8'd0);
    b_side_nxt.zero_sat = (a_hi_r == 8'd0);
    case (a_sector_r)
      rth_pkg::SectorRed:   b_side_nxt.hue_ofs = 8'd0;
      rth_pkg::SectorGreen: b_side_nxt.hue_ofs = rth_pkg::HueGreenOfs;
      rth_pkg::SectorBlue:  b_side_nxt.hue_ofs = rth_pkg::HueBlueOfs;
      default:              b_side_nxt.hue_ofs = 8'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    b_lane_r <= b_lane_nxt;
    b_side_r <= b_side_nxt;
  end

  assign out_valid = b_valid_r;
  assign out_lane  = b_lane_r;
  assign out_side  = b_side_r;

endmodule

/* hw/rtl/rth_div_stage.sv */
// ----------------------------------------------------------------------------
// rth_div_stage
// One restoring division step for the saturation and hue lanes, registered.
// ----------------------------------------------------------------------------
module rth_div_stage (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  rth_pkg::div_lane_t [1:0] in_lane,
  input  rth_pkg::side_t           in_side,
  output logic                     out_valid,
  output rth_pkg::div_lane_t [1:0] out_lane,
  output rth_pkg::side_t           out_side
);

  logic                     valid_r;
  rth_pkg::div_lane_t [1:0] lane_r;
  rth_pkg::side_t           side_r;
  rth_pkg::div_lane_t [1:0] lane_nxt;
  logic [8:0]               trial [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      trial[i]        = {in_lane[i].rem, in_lane[i].quo[7]};
      lane_nxt[i].den = in_lane[i].den;
      if (trial[i] >= {1'b0, in_lane[i].den}) begin
        lane_nxt[i].rem = 8'(trial[i] - {1'b0, in_lane[i].den});
        lane_nxt[i].quo = {in_lane[i].quo[6:0], 1'b1};
      end else begin
        lane_nxt[i].rem = trial[i][7:0];
        lane_nxt[i].quo = {in_lane[i].quo[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    side_r <= in_side;
  end

  assign out_valid = valid_r;
  assign out_lane  = lane_r;
  assign out_side  = side_r;

endmodule

/* hw/rtl/rth_post.sv */
// ----------------------------------------------------------------------------
// rth_post
// Applies the hue offset and sign, the special cases and the mode selection.
// ----------------------------------------------------------------------------
module rth_post (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  input  rth_pkg::div_lane_t [1:0] in_lane,
  input  rth_pkg::side_t           in_side,
  output logic                     out_valid,
  output rth_pkg::result_t         out_result
);

  logic             valid_r;
  rth_pkg::result_t result_r;
  rth_pkg::result_t result_nxt;
  logic [7:0]       hue_q;
  logic [7:0]       hue;
  logic [7:0]       sat;

  always_comb begin
    hue_q = in_lane[rth_pkg::LaneHue].quo;
    hue   = in_side.hue_neg ? (in_side.hue_ofs - hue_q) : (in_side.hue_ofs + hue_q);
    if (in_side.zero_hue) hue = 8'd0;
    sat = in_side.zero_sat ? 8'd0 : in_lane[rth_pkg::LaneSat].quo;
    if (in_side.mode) begin
      result_nxt.chan0_out = hue;
      result_nxt.chan1_out = sat;
      result_nxt.chan2_out = in_side.value;
    end else begin
      result_nxt.chan0_out = in_side.pix.red_in;
      result_nxt.chan1_out = in_side.pix.green_in;
      result_nxt.chan2_out = in_side.pix.blue_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    result_r <= result_nxt;
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

/* tb/sv/rgb_to_hsv_8bit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_8bit_tb
// Self-checking bench for the RGB to HSV converter. A clocked driver feeds
// pixels from a queue in bursts with random gaps. A clocked monitor compares
// every result strobe with a prediction made when the pixel was accepted.
// The mode register is rewritten between phases, only while the pipeline is
// empty. A directed set of corner pixels runs first, then random pixels in
// both modes.
// ----------------------------------------------------------------------------
module rgb_to_hsv_8bit_tb;

  localparam int FullScale   = rth_pkg::HsvFull;
  localparam int SectorWidth = rth_pkg::HueSector;
  localparam int GreenBase   = rth_pkg::HueGreenOfs;
  localparam int BlueBase    = rth_pkg::HueBlueOfs;
  localparam int StallLimit  = 1000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  rth_pkg::pixel_t  in_pixel = '0;
  logic             out_valid;
  rth_pkg::result_t out_result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_data = 1'b0;

  rth_pkg::pixel_t  pixel_q[$];
  rth_pkg::result_t hsv_q[$];
  logic             mode_q[$];
  logic             mode_now = 1'b0;

  int burst_left = 1;
  int gap_left = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_hsv = 0;
  int n_pass = 0;
  int n_grey = 0;
  int n_wrap = 0;
  int n_mode_writes = 0;

  rgb_to_hsv_8bit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_pixel  (in_pixel),
    .out_valid (out_valid),
    .out_result(out_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic rth_pkg::result_t hsv_of(rth_pkg::pixel_t p, logic hsv);
    int r, g, b, hi, lo, delta, hue, sat;
    rth_pkg::result_t res;
    r = p.red_in;
    g = p.green_in;
    b = p.blue_in;
    res = {p.red_in, p.green_in, p.blue_in};
    if (hsv) begin
      hi = r;
      lo = r;
      if (g > hi) hi = g;
      if (b > hi) hi = b;
      if (g < lo) lo = g;
      if (b < lo) lo = b;
      delta = hi - lo;
      hue = 0;
      sat = 0;
      if (hi != 0) begin
        sat = (FullScale * delta) / hi;
        if (delta == 0) hue = 0;
        else if (r == hi) hue = (SectorWidth * (g - b)) / delta;
        else if (g == hi) hue = GreenBase + (SectorWidth * (b - r)) / delta;
        else hue = BlueBase + (SectorWidth * (r - g)) / delta;
      end
      res.chan0_out = hue[7:0];
      res.chan1_out = sat[7:0];
      res.chan2_out = hi[7:0];
    end
    return res;
  endfunction

  function automatic rth_pkg::pixel_t rand_pixel();
    rth_pkg::pixel_t p;
    logic [7:0] corner[4];
    corner = '{8'd0, 8'd1, 8'd254, 8'd255};
    p = rth_pkg::pixel_t'(24'($urandom()));
    case ($urandom_range(0, 9))
      0: begin
        p.green_in = p.red_in;
        p.blue_in = p.red_in;
      end
      1: begin
        p.green_in = p.red_in;
        if (p.blue_in > p.red_in) p.blue_in = p.red_in;
      end
      2: begin
        p.blue_in = p.green_in;
        if (p.red_in > p.green_in) p.red_in = p.green_in;
      end
      3: begin
        p.red_in = corner[$urandom_range(0, 3)];
        p.green_in = corner[$urandom_range(0, 3)];
        p.blue_in = corner[$urandom_range(0, 3)];
      end
      4: begin
        p.red_in = 8'($urandom_range(128, 255));
        p.green_in = 8'($urandom_range(0, 63));
        p.blue_in = 8'($urandom_range(64, 127));
      end
      default: ;
    endcase
    return p;
  endfunction

  always @(posedge clk) begin : pixel_drv
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        hsv_q.push_back(hsv_of(in_pixel, mode_now));
        void'(pixel_q.pop_front());
        if (mode_now) begin
          n_hsv++;
          if (in_pixel.red_in == in_pixel.green_in && in_pixel.green_in == in_pixel.blue_in)
            n_grey++;
          if (in_pixel.red_in >= in_pixel.green_in && in_pixel.red_in >= in_pixel.blue_in &&
              in_pixel.blue_in > in_pixel.green_in)
            n_wrap++;
        end else begin
          n_pass++;
        end
      end
      if (start && busy) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pixel_q.size() > 0) begin
        start <= 1'b1;
        in_pixel <= pixel_q[0];
        burst_left--;
        if (burst_left <= 0) begin
          gap_left = $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                    : $urandom_range(1, 12);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : mode_drv
    if (!rst_n) begin
      cfg_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode_now = cfg_data;
        void'(mode_q.pop_front());
        n_mode_writes++;
      end
      if (cfg_valid && !cfg_ready) begin
        cfg_valid <= 1'b1;
      end else if (mode_q.size() > 0) begin
        cfg_valid <= 1'b1;
        cfg_data <= mode_q[0];
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_mon
    rth_pkg::result_t want;
    if (rst_n && out_valid) begin
      if (hsv_q.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, out_result);
      end else begin
        want = hsv_q.pop_front();
        n_checked++;
        for (int i = 0; i < 3; i++) begin
          if (want[8*(2-i) +: 8] !== out_result[8*(2-i) +: 8]) begin
            n_errors++;
            $display("%0t: chan%0d mismatch, expected %0d, actual %0d", $time, i,
                     want[8*(2-i) +: 8], out_result[8*(2-i) +: 8]);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= StallLimit) begin
      $display("%0t: no transaction for %0d cycles", $time, StallLimit);
      $display("rgb_to_hsv_8bit_tb NOT OK");
      $finish;
    end
  end

  task automatic wait_idle();
    do @(negedge clk);
    while (pixel_q.size() > 0 || hsv_q.size() > 0 || mode_q.size() > 0 || start || cfg_valid);
    repeat (rth_pkg::Latency) @(negedge clk);
  endtask

  task automatic set_mode(logic hsv);
    wait_idle();
    mode_q.push_back(hsv);
    wait_idle();
  endtask

  task automatic add_pixel(int r, int g, int b);
    pixel_q.push_back({8'(r), 8'(g), 8'(b)});
  endtask

  initial begin : stimulus
    logic phase_mode[6];
    phase_mode = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_mode(1'b0);
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(255, 0, 170);
    add_pixel(1, 128, 254);

    set_mode(1'b1);
    add_pixel(0, 0, 0);
    add_pixel(255, 255, 255);
    add_pixel(128, 128, 128);
    add_pixel(1, 1, 1);
    add_pixel(255, 0, 0);
    add_pixel(0, 255, 0);
    add_pixel(0, 0, 255);
    add_pixel(200, 200, 10);
    add_pixel(90, 5, 90);
    add_pixel(3, 250, 250);
    add_pixel(255, 0, 1);
    add_pixel(255, 0, 254);
    add_pixel(200, 10, 100);
    add_pixel(255, 255, 0);
    add_pixel(255, 0, 255);
    add_pixel(0, 255, 255);
    add_pixel(100, 255, 0);
    add_pixel(0, 10, 255);
    add_pixel(1, 0, 0);
    add_pixel(255, 254, 254);
    add_pixel(254, 255, 0);

    foreach (phase_mode[k]) begin
      set_mode(phase_mode[k]);
      repeat (150) pixel_q.push_back(rand_pixel());
    end

    wait_idle();
    repeat (rth_pkg::Latency + 4) @(posedge clk);
    $display("Checked %0d pixels: %0d in HSV mode (%0d grey or black, %0d with wrapped hue),",
             n_checked, n_hsv, n_grey, n_wrap);
    $display("%0d passed through, across %0d mode register writes.", n_pass, n_mode_writes);
    if (n_errors == 0) $display("rgb_to_hsv_8bit_tb OK");
    else $display("rgb_to_hsv_8bit_tb NOT OK");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/rth_pkg.sv
hw/rtl/rth_prep.sv
hw/rtl/rth_div_stage.sv
hw/rtl/rth_post.sv
hw/rtl/rgb_to_hsv_8bit.sv
tb/sv/rgb_to_hsv_8bit_tb.sv
